[rtl/core/aabb_pkg.sv]
`default_nettype none

package aabb_pkg;

  localparam int CoordWidthDef = 32;
  localparam int FracBitsDef   = 16;
  localparam int DistWidth     = 64;
  localparam int ReqTypeWidth  = 3;
  localparam int CfgIdxWidth   = 3;

  // result scale: squared distance carries this many fraction bits
  localparam int DistFracBits  = 32;

  typedef enum logic [ReqTypeWidth-1:0] {
    REQ_RAY          = 3'd0,
    REQ_OVERLAP      = 3'd1,
    REQ_CONTAINS_BOX = 3'd2,
    REQ_CONTAINS_PT  = 3'd3,
    REQ_SQR_DIST     = 3'd4
  } req_type_e;

  localparam logic [CfgIdxWidth-1:0] CfgMinX = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgMinY = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgMinZ = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgMaxX = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgMaxY = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgMaxZ = 3'd5;

endpackage

`default_nettype wire

[rtl/core/aabb_if.sv]
`default_nettype none

interface aabb_req_if import aabb_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef
);
  logic                          valid;
  logic                          ready;
  logic [ReqTypeWidth-1:0]       req_type;
  logic signed [COORD_WIDTH-1:0] vec_a_x;
  logic signed [COORD_WIDTH-1:0] vec_a_y;
  logic signed [COORD_WIDTH-1:0] vec_a_z;
  logic signed [COORD_WIDTH-1:0] vec_b_x;
  logic signed [COORD_WIDTH-1:0] vec_b_y;
  logic signed [COORD_WIDTH-1:0] vec_b_z;

  modport source (
    output valid, req_type, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
    output ready
  );
endinterface

interface aabb_rsp_if import aabb_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [DistWidth-1:0] sqr_distance;

  modport source (
    output valid, hit, sqr_distance,
    input  ready
  );
  modport sink (
    input  valid, hit, sqr_distance,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/aabb_query_unit.sv]
`default_nettype none

// channel   direction  word
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i (box corner register write)
// req_i     in         req_type, vec_a_x/y/z, vec_b_x/y/z
// rsp_o     out        hit, sqr_distance
//
// four register stages: subtract/compare, multiply, slab order and scale,
// min/max reduce and saturating sum; rsp_o.valid is the valid bit of the fourth stage
// one word per cycle sustained while rsp_o.ready is high; the six 33x32 slab multipliers set the stage depth
// each stage holds its word while the next one is full and stalled, bubbles are filled
// so req_i.ready stays high while the output waits unless all stages are full
// rst_ni clears the valid bits and the box registers to zero

module aabb_query_unit import aabb_pkg::*; #(
  parameter int COORD_WIDTH = CoordWidthDef,
  parameter int FRAC_BITS   = FracBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0] cfg_data_i,
  aabb_req_if.sink                    req_i,
  aabb_rsp_if.source                  rsp_o
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * COORD_WIDTH + 1;
  localparam int SW    = 2 * COORD_WIDTH;
  localparam int Shift = DistFracBits - 2 * FRAC_BITS;
  localparam int ShUp  = (Shift > 0) ? Shift : 0;
  localparam int ShDn  = (Shift < 0) ? -Shift : 0;

  // box registers
  logic signed [COORD_WIDTH-1:0] box_min_q [3];
  logic signed [COORD_WIDTH-1:0] box_max_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinX: box_min_q[0] <= cfg_data_i;
        CfgMinY: box_min_q[1] <= cfg_data_i;
        CfgMinZ: box_min_q[2] <= cfg_data_i;
        CfgMaxX: box_max_q[0] <= cfg_data_i;
        CfgMaxY: box_max_q[1] <= cfg_data_i;
        CfgMaxZ: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake chain
  logic [4:1] vld_q;
  logic [5:1] adv;

  always_comb begin
    adv[5] = rsp_o.ready;
    for (int k = 4; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end
  assign req_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) vld_q[1] <= req_i.valid;
      for (int k = 2; k <= 4; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: slab distances, gaps and box compares
  logic signed [COORD_WIDTH-1:0] a_in [3];
  logic signed [COORD_WIDTH-1:0] b_in [3];
  logic signed [DW-1:0]          bmin_e [3];
  logic signed [DW-1:0]          bmax_e [3];
  logic signed [DW-1:0]          a_e [3];
  logic signed [DW-1:0]          d_lo_d [3];
  logic signed [DW-1:0]          d_hi_d [3];
  logic signed [DW-1:0]          d_out [3];
  logic [COORD_WIDTH-1:0]        gap_d [3];
  logic                          ovl_ok, cbox_ok, cpt_ok;
  logic                          cmp_hit_d, is_ray_d, is_dist_d;

  assign a_in[0] = req_i.vec_a_x;
  assign a_in[1] = req_i.vec_a_y;
  assign a_in[2] = req_i.vec_a_z;
  assign b_in[0] = req_i.vec_b_x;
  assign b_in[1] = req_i.vec_b_y;
  assign b_in[2] = req_i.vec_b_z;

  always_comb begin
    ovl_ok  = 1'b1;
    cbox_ok = 1'b1;
    cpt_ok  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      bmin_e[i] = DW'(box_min_q[i]);
      bmax_e[i] = DW'(box_max_q[i]);
      a_e[i]    = DW'(a_in[i]);
      d_lo_d[i] = bmin_e[i] - a_e[i];
      d_hi_d[i] = bmax_e[i] - a_e[i];
      d_out[i]  = a_e[i] - bmax_e[i];
      if (a_in[i] < box_min_q[i]) begin
        gap_d[i] = d_lo_d[i][COORD_WIDTH-1:0];
      end else if (a_in[i] > box_max_q[i]) begin
        gap_d[i] = d_out[i][COORD_WIDTH-1:0];
      end else begin
        gap_d[i] = '0;
      end
      if (box_max_q[i] < a_in[i] || box_min_q[i] > b_in[i]) ovl_ok = 1'b0;
      if (!(box_min_q[i] <= a_in[i] && b_in[i] <= box_max_q[i])) cbox_ok = 1'b0;
      if (!(box_min_q[i] <= a_in[i] && a_in[i] <= box_max_q[i])) cpt_ok = 1'b0;
    end
  end

  always_comb begin
    cmp_hit_d = 1'b0;
    is_ray_d  = 1'b0;
    is_dist_d = 1'b0;
    unique case (req_type_e'(req_i.req_type))
      REQ_RAY:          is_ray_d  = 1'b1;
      REQ_OVERLAP:      cmp_hit_d = ovl_ok;
      REQ_CONTAINS_BOX: cmp_hit_d = cbox_ok;
      REQ_CONTAINS_PT:  cmp_hit_d = cpt_ok;
      REQ_SQR_DIST:     is_dist_d = 1'b1;
      default: ;
    endcase
  end

  logic signed [DW-1:0]          s1_dlo_q [3];
  logic signed [DW-1:0]          s1_dhi_q [3];
  logic signed [COORD_WIDTH-1:0] s1_inv_q [3];
  logic [COORD_WIDTH-1:0]        s1_gap_q [3];
  logic                          s1_cmp_q, s1_ray_q, s1_dist_q;

  always_ff @(posedge clk_i) begin
    if (adv[1] && req_i.valid) begin
      for (int i = 0; i < 3; i++) begin
        s1_dlo_q[i] <= d_lo_d[i];
        s1_dhi_q[i] <= d_hi_d[i];
        s1_inv_q[i] <= b_in[i];
        s1_gap_q[i] <= gap_d[i];
      end
      s1_cmp_q  <= cmp_hit_d;
      s1_ray_q  <= is_ray_d;
      s1_dist_q <= is_dist_d;
    end
  end

  // stage 2: slab products and gap squares
  logic signed [PW-1:0] t1_d [3];
  logic signed [PW-1:0] t2_d [3];
  logic [SW-1:0]        sq_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1_d[i] = PW'(s1_dlo_q[i]) * PW'(s1_inv_q[i]);
      t2_d[i] = PW'(s1_dhi_q[i]) * PW'(s1_inv_q[i]);
      sq_d[i] = SW'(s1_gap_q[i]) * SW'(s1_gap_q[i]);
    end
  end

  logic signed [PW-1:0] s2_t1_q [3];
  logic signed [PW-1:0] s2_t2_q [3];
  logic [SW-1:0]        s2_sq_q [3];
  logic                 s2_cmp_q, s2_ray_q, s2_dist_q;

  always_ff @(posedge clk_i) begin
    if (adv[2] && vld_q[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_t1_q[i] <= t1_d[i];
        s2_t2_q[i] <= t2_d[i];
        s2_sq_q[i] <= sq_d[i];
      end
      s2_cmp_q  <= s1_cmp_q;
      s2_ray_q  <= s1_ray_q;
      s2_dist_q <= s1_dist_q;
    end
  end

  // stage 3: near/far per slab, square scaled to the result format
  logic signed [PW-1:0] lo_d [3];
  logic signed [PW-1:0] hi_d [3];
  logic [DistWidth-1:0] sq64 [3];
  logic [DistWidth-1:0] term_d [3];
  logic                 sat_up;

  always_comb begin
    sat_up = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s2_t1_q[i] < s2_t2_q[i]) begin
        lo_d[i] = s2_t1_q[i];
        hi_d[i] = s2_t2_q[i];
      end else begin
        lo_d[i] = s2_t2_q[i];
        hi_d[i] = s2_t1_q[i];
      end
      sq64[i] = DistWidth'(s2_sq_q[i]);
      sat_up  = (ShUp > 0) && ((sq64[i] >> (DistWidth - ShUp)) != '0);
      term_d[i] = sat_up ? '1 : ((sq64[i] << ShUp) >> ShDn);
    end
  end

  logic signed [PW-1:0] s3_lo_q [3];
  logic signed [PW-1:0] s3_hi_q [3];
  logic [DistWidth-1:0] s3_term_q [3];
  logic                 s3_cmp_q, s3_ray_q, s3_dist_q;

  always_ff @(posedge clk_i) begin
    if (adv[3] && vld_q[2]) begin
      for (int i = 0; i < 3; i++) begin
        s3_lo_q[i]   <= lo_d[i];
        s3_hi_q[i]   <= hi_d[i];
        s3_term_q[i] <= term_d[i];
      end
      s3_cmp_q  <= s2_cmp_q;
      s3_ray_q  <= s2_ray_q;
      s3_dist_q <= s2_dist_q;
    end
  end

  // stage 4: entry/exit reduce and saturating sum
  logic signed [PW-1:0]   tmin, tmax, tnear;
  logic                   ray_hit;
  logic [DistWidth+1:0]   sum3;
  logic [DistWidth-1:0]   dist_d;
  logic                   hit_d;

  always_comb begin
    tmin = s3_lo_q[0];
    tmax = s3_hi_q[0];
    for (int i = 1; i < 3; i++) begin
      if (s3_lo_q[i] > tmin) tmin = s3_lo_q[i];
      if (s3_hi_q[i] < tmax) tmax = s3_hi_q[i];
    end
    tnear   = (tmin > 0) ? tmin : '0;
    ray_hit = tmax > tnear;
    sum3    = (DistWidth+2)'(s3_term_q[0]) + (DistWidth+2)'(s3_term_q[1])
            + (DistWidth+2)'(s3_term_q[2]);
    if (!s3_dist_q) begin
      dist_d = '0;
    end else if (sum3[DistWidth+1:DistWidth] != 2'b00) begin
      dist_d = '1;
    end else begin
      dist_d = sum3[DistWidth-1:0];
    end
    hit_d = s3_ray_q ? ray_hit : s3_cmp_q;
  end

  logic                 out_hit_q;
  logic [DistWidth-1:0] out_dist_q;

  always_ff @(posedge clk_i) begin
    if (adv[4] && vld_q[3]) begin
      out_hit_q  <= hit_d;
      out_dist_q <= dist_d;
    end
  end

  assign rsp_o.valid        = vld_q[4];
  assign rsp_o.hit          = out_hit_q;
  assign rsp_o.sqr_distance = out_dist_q;

  // checks
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> (vld_q == '1))
    else $error("input blocked with a free stage");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> vld_q[1])
    else $error("accepted word lost at first stage");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[2] && !adv[2]) |=> (vld_q[2] && $stable(s2_ray_q) && $stable(s2_dist_q)))
    else $error("stalled stage dropped its word");

  a_one_field_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.hit && (rsp_o.sqr_distance != '0)))
    else $error("hit and distance both set");

endmodule

`default_nettype wire

[tb/aabb_query_unit_test.sv]
`timescale 1ns / 1ps

module aabb_query_unit_test;
  import aabb_pkg::*;

  typedef logic signed [CoordWidthDef-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  typedef struct packed {
    logic [ReqTypeWidth-1:0] kind;
    vec3_t                   a;
    vec3_t                   b;
  } query_t;

  typedef struct packed {
    logic                 hit;
    logic [DistWidth-1:0] sqd;
  } answer_t;

  // a box row programs all six corner registers, the others issue one query
  typedef struct packed {
    logic    is_box;
    query_t  q;
    logic    typed;
    answer_t want;
  } dir_row_t;

  localparam logic [ReqTypeWidth-1:0] ReqUnused5 = 3'd5;
  localparam logic [ReqTypeWidth-1:0] ReqUnused6 = 3'd6;
  localparam logic [ReqTypeWidth-1:0] ReqUnused7 = 3'd7;

  localparam coord_t CoordMin = 32'sh8000_0000;
  localparam coord_t CoordMax = 32'sh7fff_ffff;
  localparam coord_t FixOne   = 32'sh0001_0000;

  localparam int RandPhases     = 8;
  localparam int QueriesPerBox  = 112;
  localparam int IdleLimit      = 2000;
  localparam int MaxShown       = 10;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [CoordWidthDef-1:0] cfg_data_i;
  logic                   rsp_take = 1'b0;

  aabb_req_if #(.COORD_WIDTH(CoordWidthDef)) req_if ();
  aabb_rsp_if rsp_if ();

  assign rsp_if.ready = rsp_take;

  aabb_query_unit #(
    .COORD_WIDTH(CoordWidthDef),
    .FRAC_BITS  (FracBitsDef)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  coord_t   box_lo [3];
  coord_t   box_hi [3];
  answer_t  pending [$];
  dir_row_t directed [$];
  int       served [8];
  int       box_settings = 0;
  int       results_seen = 0;
  int       mismatches = 0;
  int       burst_left = 0;
  int       cycle_cnt = 0;
  int       stall_cycles = 0;

  function automatic vec3_t v3(coord_t x, coord_t y, coord_t z);
    vec3_t r;
    r[0] = x;
    r[1] = y;
    r[2] = z;
    return r;
  endfunction

  function automatic dir_row_t box_row(vec3_t lo, vec3_t hi);
    dir_row_t r;
    r = '0;
    r.is_box = 1'b1;
    r.q.a = lo;
    r.q.b = hi;
    return r;
  endfunction

  function automatic dir_row_t q_row(logic [ReqTypeWidth-1:0] kind, vec3_t a, vec3_t b,
                                     logic typed, logic hit, logic [DistWidth-1:0] sqd);
    dir_row_t r;
    r = '0;
    r.q.kind = kind;
    r.q.a = a;
    r.q.b = b;
    r.typed = typed;
    r.want.hit = hit;
    r.want.sqd = sqd;
    return r;
  endfunction

  // exact slab test, containment checks and squared distance against the programmed box
  function automatic answer_t predict_query(query_t q);
    answer_t r;
    longint mn, mx, pa, pb, t1, t2, tlo, thi, tnear, tfar;
    longint unsigned gap, sq;
    logic [DistWidth:0] sum;
    r = '0;
    tnear = 0;
    tfar = 0;
    if (q.kind inside {REQ_OVERLAP, REQ_CONTAINS_BOX, REQ_CONTAINS_PT}) r.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      mn = box_lo[i];
      mx = box_hi[i];
      pa = $signed(q.a[i]);
      pb = $signed(q.b[i]);
      case (q.kind)
        REQ_RAY: begin
          t1 = (mn - pa) * pb;
          t2 = (mx - pa) * pb;
          tlo = (t1 < t2) ? t1 : t2;
          thi = (t1 < t2) ? t2 : t1;
          if (i == 0 || tlo > tnear) tnear = tlo;
          if (i == 0 || thi < tfar) tfar = thi;
        end
        REQ_OVERLAP: if (mx < pa || mn > pb) r.hit = 1'b0;
        REQ_CONTAINS_BOX: if (!(mn <= pa && pb <= mx)) r.hit = 1'b0;
        REQ_CONTAINS_PT: if (!(mn <= pa && pa <= mx)) r.hit = 1'b0;
        REQ_SQR_DIST: begin
          gap = 0;
          if (pa < mn) gap = longint'(mn - pa);
          else if (pa > mx) gap = longint'(pa - mx);
          sq = gap * gap;
          sum = {1'b0, r.sqd} + {1'b0, sq};
          r.sqd = sum[DistWidth] ? '1 : sum[DistWidth-1:0];
        end
        default: ;
      endcase
    end
    if (q.kind == REQ_RAY) r.hit = tfar > ((tnear > 0) ? tnear : 0);
    return r;
  endfunction

  function automatic coord_t rand_between(longint lo, longint hi);
    longint unsigned span, r;
    span = longint'(hi - lo + 1);
    r = {$urandom, $urandom};
    return coord_t'(lo + longint'(r % span));
  endfunction

  function automatic int any_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 6) return 1;
    if (r < 8) return 2;
    return (r == 8) ? 3 : 4;
  endfunction

  // 0 anywhere, 1 inside the axis span, 2 next to a face, 3 extremes, 4 near the box
  function automatic coord_t pick_coord(int axis, int mode);
    coord_t lo, hi, c;
    lo = (box_lo[axis] < box_hi[axis]) ? box_lo[axis] : box_hi[axis];
    hi = (box_lo[axis] < box_hi[axis]) ? box_hi[axis] : box_lo[axis];
    c = $urandom_range(0, 1) ? box_lo[axis] : box_hi[axis];
    case (mode)
      0: return $urandom;
      1: return rand_between(lo, hi);
      2: return c + coord_t'($urandom_range(0, 6)) - coord_t'(3);
      3: begin
        case ($urandom_range(0, 4))
          0: return CoordMin;
          1: return CoordMax;
          2: return coord_t'(0);
          3: return coord_t'(-1);
          default: return coord_t'(1);
        endcase
      end
      default: return c + rand_between(-(1 << 20), 1 << 20);
    endcase
  endfunction

  // inverse direction: saturated for axis-parallel rays, zero, short or anything
  function automatic coord_t pick_inv();
    case ($urandom_range(0, 9))
      0: return CoordMax;
      1: return CoordMin;
      2: return coord_t'(0);
      3, 4, 5, 6: return rand_between(-(1 << 18), 1 << 18);
      default: return $urandom;
    endcase
  endfunction

  function automatic query_t make_query();
    query_t q;
    coord_t p1, p2;
    if ($urandom_range(0, 99) < 5) q.kind = 3'($urandom_range(ReqUnused5, ReqUnused7));
    else q.kind = 3'($urandom_range(REQ_RAY, REQ_SQR_DIST));
    for (int i = 0; i < 3; i++) begin
      case (q.kind)
        REQ_RAY: begin
          q.a[i] = pick_coord(i, any_mode());
          q.b[i] = pick_inv();
        end
        REQ_OVERLAP, REQ_CONTAINS_BOX: begin
          p1 = pick_coord(i, any_mode());
          p2 = pick_coord(i, any_mode());
          if ($urandom_range(0, 3) != 0 && p1 > p2) {p1, p2} = {p2, p1};
          q.a[i] = p1;
          q.b[i] = p2;
        end
        default: begin
          q.a[i] = pick_coord(i, any_mode());
          q.b[i] = $urandom;
        end
      endcase
    end
    return q;
  endfunction

  // 0 small near origin, 1 wide sorted, 2 unsorted, 3 extreme faces, 4 flat
  task automatic random_box(int shape, output vec3_t lo, output vec3_t hi);
    coord_t p1, p2;
    for (int i = 0; i < 3; i++) begin
      case (shape)
        0: begin
          p1 = rand_between(-(1 << 20), 1 << 20);
          p2 = p1 + coord_t'($urandom_range(0, 1 << 19));
        end
        1: begin
          p1 = $urandom;
          p2 = $urandom;
          if (p1 > p2) {p1, p2} = {p2, p1};
        end
        2: begin
          p1 = $urandom;
          p2 = $urandom;
        end
        3: begin
          p1 = $urandom_range(0, 1) ? CoordMin : coord_t'($urandom);
          p2 = $urandom_range(0, 1) ? CoordMax : coord_t'($urandom);
        end
        default: begin
          p1 = rand_between(-(1 << 20), 1 << 20);
          p2 = p1;
        end
      endcase
      lo[i] = p1;
      hi[i] = p2;
    end
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, coord_t val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgMinX: box_lo[0] = val;
      CfgMinY: box_lo[1] = val;
      CfgMinZ: box_lo[2] = val;
      CfgMaxX: box_hi[0] = val;
      CfgMaxY: box_hi[1] = val;
      CfgMaxZ: box_hi[2] = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // wait for every result before touching the box registers
  task automatic program_box(vec3_t lo, vec3_t hi);
    req_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    write_reg(CfgMinX, lo[0]);
    write_reg(CfgMinY, lo[1]);
    write_reg(CfgMinZ, lo[2]);
    write_reg(CfgMaxX, hi[0]);
    write_reg(CfgMaxY, hi[1]);
    write_reg(CfgMaxZ, hi[2]);
    cfg_we_i <= 1'b0;
    box_settings++;
  endtask

  task automatic sender_pause();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_query(query_t q, logic typed, answer_t want);
    req_if.valid <= 1'b1;
    req_if.req_type <= q.kind;
    req_if.vec_a_x <= q.a[0];
    req_if.vec_a_y <= q.a[1];
    req_if.vec_a_z <= q.a[2];
    req_if.vec_b_x <= q.b[0];
    req_if.vec_b_y <= q.b[1];
    req_if.vec_b_z <= q.b[2];
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending.push_back(typed ? want : predict_query(q));
    served[q.kind]++;
  endtask

  task automatic flag_mismatch(string field, logic [63:0] exp_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= MaxShown)
      $display("mismatch on %s at result %0d: expected %h, got %h",
               field, results_seen, exp_v, got_v);
  endtask

  // response checking and receiver stall pattern
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && rsp_if.valid && rsp_take) begin
      results_seen++;
      if (pending.size() == 0) begin
        flag_mismatch("word with no query pending", '0, rsp_if.sqr_distance);
      end else begin
        want = pending.pop_front();
        if (rsp_if.hit !== want.hit) flag_mismatch("hit", 64'(want.hit), 64'(rsp_if.hit));
        if (rsp_if.sqr_distance !== want.sqd)
          flag_mismatch("sqr_distance", want.sqd, rsp_if.sqr_distance);
      end
    end
    case (cycle_cnt[8:7])
      2'd0: rsp_take <= 1'b1;
      2'd1: rsp_take <= 1'($urandom_range(0, 1));
      2'd2: rsp_take <= (cycle_cnt[1:0] == 2'd0);
      default: rsp_take <= (cycle_cnt[4:0] > 5'd19);
    endcase
    cycle_cnt <= cycle_cnt + 1;
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_take)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == IdleLimit) begin
      $display("no word moved for %0d cycles", IdleLimit);
      $display("** aabb_query_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    vec3_t lo, hi;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.req_type = '0;
    req_if.vec_a_x = '0;
    req_if.vec_a_y = '0;
    req_if.vec_a_z = '0;
    req_if.vec_b_x = '0;
    req_if.vec_b_y = '0;
    req_if.vec_b_z = '0;
    for (int i = 0; i < 3; i++) begin
      box_lo[i] = '0;
      box_hi[i] = '0;
    end

    // box after reset is the single point at the origin
    directed.push_back(q_row(REQ_CONTAINS_PT, v3(0, 0, 0), v3(0, 0, 0), 1, 1, 0));
    directed.push_back(q_row(REQ_SQR_DIST, v3(CoordMin, CoordMin, CoordMin), v3(0, 0, 0),
                             1, 0, 64'hc000_0000_0000_0000));
    directed.push_back(q_row(ReqUnused5, v3(CoordMax, CoordMax, CoordMax),
                             v3(CoordMin, CoordMin, CoordMin), 1, 0, 0));
    directed.push_back(q_row(ReqUnused6, v3(0, 0, 0), v3(0, 0, 0), 1, 0, 0));
    directed.push_back(q_row(ReqUnused7, v3(CoordMin, CoordMin, CoordMin),
                             v3(CoordMax, CoordMax, CoordMax), 1, 0, 0));
    directed.push_back(q_row(REQ_RAY, v3(0, 0, 0), v3(FixOne, FixOne, FixOne), 0, 0, 0));
    // whole coordinate range
    directed.push_back(box_row(v3(CoordMin, CoordMin, CoordMin),
                               v3(CoordMax, CoordMax, CoordMax)));
    directed.push_back(q_row(REQ_CONTAINS_PT, v3(CoordMax, CoordMin, 0), v3(0, 0, 0), 1, 1, 0));
    directed.push_back(q_row(REQ_CONTAINS_BOX, v3(CoordMin, CoordMin, CoordMin),
                             v3(CoordMax, CoordMax, CoordMax), 1, 1, 0));
    directed.push_back(q_row(REQ_OVERLAP, v3(CoordMax, CoordMax, CoordMax),
                             v3(CoordMax, CoordMax, CoordMax), 1, 1, 0));
    directed.push_back(q_row(REQ_SQR_DIST, v3(CoordMax, CoordMin, -1), v3(0, 0, 0), 1, 0, 0));
    directed.push_back(q_row(REQ_RAY, v3(CoordMin, CoordMin, CoordMin),
                             v3(CoordMax, CoordMax, CoordMax), 0, 0, 0));
    directed.push_back(q_row(REQ_RAY, v3(CoordMax, 0, CoordMin),
                             v3(CoordMin, CoordMin, CoordMin), 0, 0, 0));
    // flat box in the far corner, distance saturates
    directed.push_back(box_row(v3(CoordMax, CoordMax, CoordMax),
                               v3(CoordMax, CoordMax, CoordMax)));
    directed.push_back(q_row(REQ_SQR_DIST, v3(CoordMin, CoordMin, CoordMin), v3(0, 0, 0),
                             1, 0, '1));
    directed.push_back(q_row(REQ_RAY, v3(CoordMin, 0, CoordMax), v3(0, 0, 0), 1, 0, 0));
    directed.push_back(q_row(REQ_CONTAINS_PT, v3(CoordMax, CoordMax, CoordMax),
                             v3(0, 0, 0), 1, 1, 0));
    // unit box, axis-parallel rays
    directed.push_back(box_row(v3(-FixOne, -FixOne, -FixOne), v3(FixOne, FixOne, FixOne)));
    directed.push_back(q_row(REQ_RAY, v3(-5 * FixOne, 0, 0), v3(FixOne, CoordMax, CoordMax),
                             0, 0, 0));
    directed.push_back(q_row(REQ_RAY, v3(-5 * FixOne, 2 * FixOne, 0),
                             v3(FixOne, CoordMax, CoordMax), 0, 0, 0));
    directed.push_back(q_row(REQ_RAY, v3(5 * FixOne, 0, 0), v3(-FixOne, CoordMin, CoordMin),
                             0, 0, 0));
    directed.push_back(q_row(REQ_OVERLAP, v3(0, 0, 0), v3(3 * FixOne, 3 * FixOne, 3 * FixOne),
                             0, 0, 0));
    directed.push_back(q_row(REQ_CONTAINS_BOX, v3(-FixOne / 2, -FixOne / 2, -FixOne / 2),
                             v3(2 * FixOne, FixOne / 2, FixOne / 2), 0, 0, 0));
    directed.push_back(q_row(REQ_SQR_DIST, v3(3 * FixOne, -2 * FixOne, FixOne / 2),
                             v3(0, 0, 0), 0, 0, 0));
    // inverted box, min above max
    directed.push_back(box_row(v3(FixOne, FixOne, FixOne), v3(-FixOne, -FixOne, -FixOne)));
    directed.push_back(q_row(REQ_CONTAINS_PT, v3(0, 0, 0), v3(0, 0, 0), 0, 0, 0));
    directed.push_back(q_row(REQ_SQR_DIST, v3(0, 0, 0), v3(0, 0, 0), 0, 0, 0));
    directed.push_back(q_row(REQ_RAY, v3(-5 * FixOne, 0, 0), v3(FixOne, CoordMax, CoordMax),
                             0, 0, 0));
    directed.push_back(q_row(REQ_OVERLAP, v3(-2 * FixOne, -2 * FixOne, -2 * FixOne),
                             v3(2 * FixOne, 2 * FixOne, 2 * FixOne), 0, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[n]) begin
      if (directed[n].is_box) begin
        program_box(directed[n].q.a, directed[n].q.b);
      end else begin
        sender_pause();
        send_query(directed[n].q, directed[n].typed, directed[n].want);
      end
    end

    for (int phase = 0; phase < RandPhases; phase++) begin
      random_box((phase < 5) ? phase : $urandom_range(0, 1), lo, hi);
      program_box(lo, hi);
      repeat (QueriesPerBox) begin
        sender_pause();
        send_query(make_query(), 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("queries: %0d ray, %0d overlap, %0d box containment, %0d point containment,",
             served[REQ_RAY], served[REQ_OVERLAP], served[REQ_CONTAINS_BOX],
             served[REQ_CONTAINS_PT]);
    $display("  %0d distance, %0d undefined type; %0d box settings, %0d words checked",
             served[REQ_SQR_DIST], served[ReqUnused5] + served[ReqUnused6] +
             served[ReqUnused7], box_settings, results_seen);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("** aabb_query_unit: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** aabb_query_unit: FAILED **");
    end
    $finish;
  end

endmodule
